// ===== hdl/sprq_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ready queue package
// Shared widths, defaults, operation codes and the command that the
// control logic sends to every cell of the queue.
// ----------------------------------------------------------------------------
package sprq_pkg;

	localparam int PRIO_W = 8;
	localparam int ID_W = 4;
	localparam int SLOT_COUNT_DEF = 16;
	localparam logic [PRIO_W-1:0] IDLE_PRIO_DEF = 8'd255;

	typedef enum logic [1:0] {
		KIND_CREATE   = 2'd0,
		KIND_EXIT     = 2'd1,
		KIND_YIELD    = 2'd2,
		KIND_SET_PRIO = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		CELL_HOLD,
		CELL_SHIFT,
		CELL_MARK,
		CELL_BUBBLE,
		CELL_INSERT
	} cell_op_t;

	typedef struct packed {
		cell_op_t          op;
		logic [PRIO_W-1:0] key_prio;
	} cell_cmd_t;

endpackage

// ===== hdl/sprq_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ready queue cell
// Holds one queue entry and moves it to or from its neighbors on the
// broadcast command: shift toward the head, mark, hole bubble, insert.
// ----------------------------------------------------------------------------
module sprq_cell #(
	parameter int SLOT_W = 4,
	parameter logic [sprq_pkg::PRIO_W-1:0] IDLE_PRIORITY = sprq_pkg::IDLE_PRIO_DEF,
	parameter bit IS_HEAD = 1'b0
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  sprq_pkg::cell_cmd_t         cmd,
	input  logic [SLOT_W-1:0]           key_slot,
	input  logic                        left_valid,
	input  logic [SLOT_W-1:0]           left_slot,
	input  logic [sprq_pkg::PRIO_W-1:0] left_prio,
	input  logic                        left_hole,
	input  logic                        left_gt,
	input  logic                        right_valid,
	input  logic [SLOT_W-1:0]           right_slot,
	input  logic [sprq_pkg::PRIO_W-1:0] right_prio,
	output logic                        valid,
	output logic                        hole,
	output logic [SLOT_W-1:0]           slot,
	output logic [sprq_pkg::PRIO_W-1:0] prio,
	output logic                        gt
);
	import sprq_pkg::*;

	logic              valid_q;
	logic              hole_q;
	logic [SLOT_W-1:0] slot_q;
	logic [PRIO_W-1:0] prio_q;

	assign valid = valid_q;
	assign hole  = hole_q;
	assign slot  = slot_q;
	assign prio  = prio_q;
	assign gt    = !valid_q || (prio_q > cmd.key_prio);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= IS_HEAD;
			hole_q  <= 1'b0;
			slot_q  <= '0;
			prio_q  <= IDLE_PRIORITY;
		end else begin
			unique case (cmd.op)
				CELL_HOLD: begin
				end
				CELL_SHIFT: begin
					valid_q <= right_valid;
					slot_q  <= right_slot;
					prio_q  <= right_prio;
					hole_q  <= 1'b0;
				end
				CELL_MARK: begin
					if (valid_q && slot_q == key_slot) begin
						hole_q <= 1'b1;
					end
				end
				CELL_BUBBLE: begin
					if (hole_q) begin
						valid_q <= right_valid;
						slot_q  <= right_slot;
						prio_q  <= right_prio;
						hole_q  <= 1'b0;
					end else if (left_hole && valid_q) begin
						hole_q <= 1'b1;
					end
				end
				CELL_INSERT: begin
					if (gt) begin
						if (left_gt) begin
							valid_q <= left_valid;
							slot_q  <= left_slot;
							prio_q  <= left_prio;
						end else begin
							valid_q <= 1'b1;
							slot_q  <= key_slot;
							prio_q  <= cmd.key_prio;
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

endmodule

// ===== hdl/strict_priority_ready_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Strict priority ready queue
// Task scheduler queue built as a row of cells sorted by priority, with
// first-come order among equal priorities and the idle task at the back.
// ----------------------------------------------------------------------------
// The slave stream carries one operation per beat: tuser holds the kind
// (create, exit, yield, set priority), tdata the target task and priority.
// The master stream returns one result beat per operation with the running
// task, the created slot, a switch flag and an error flag.
// Create and a yield that moves the running task pass through decide,
// insert and done between accept and result; exit, a yield that changes
// nothing and rejected operations go from decide straight to done. Set
// priority marks the target, then lets the gap it leaves travel one
// cell per cycle toward the tail before the task is inserted again.
// Insertion happens in the insert state: every cell compares the new
// priority at once and shifts toward the tail where needed.
// After reset only the idle task is queued and active. A new operation is
// accepted as soon as the previous one is finished, even while its result
// still waits; if the receiver stalls, the next result is held until the
// output register is free, and input stays blocked meanwhile.
// ----------------------------------------------------------------------------
module strict_priority_ready_queue #(
	parameter int SLOT_COUNT = sprq_pkg::SLOT_COUNT_DEF,
	parameter logic [sprq_pkg::PRIO_W-1:0] IDLE_PRIORITY = sprq_pkg::IDLE_PRIO_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,  // task_id[3:0], priority_req[11:4]
	input  logic [1:0]  s_axis_tuser,  // kind[1:0]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [7:0]  m_axis_tdata,  // running_task[3:0], created_task[7:4]
	output logic [1:0]  m_axis_tuser   // switched[0], error[1]
);
	import sprq_pkg::*;

	localparam int SLOT_W = $clog2(SLOT_COUNT);

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECIDE,
		S_MARK,
		S_BUBBLE,
		S_INSERT,
		S_DONE
	} state_t;

	state_t              state_q;
	kind_t               kind_q;
	logic [ID_W-1:0]     tid_q;
	logic [PRIO_W-1:0]   prio_q;
	logic [SLOT_W-1:0]   before_q;
	logic [SLOT_W-1:0]   key_slot_q;
	logic [PRIO_W-1:0]   key_prio_q;
	logic [SLOT_W-1:0]   created_q;
	logic                err_q;
	logic [SLOT_COUNT-1:0] active_q;
	logic                m_tvalid_q;
	logic [7:0]          m_tdata_q;
	logic [1:0]          m_tuser_q;

	logic [SLOT_COUNT-1:0] cell_valid;
	logic [SLOT_COUNT-1:0] cell_hole;
	logic [SLOT_COUNT-1:0] cell_gt;
	logic [SLOT_W-1:0]    cell_slot [SLOT_COUNT];
	logic [PRIO_W-1:0]    cell_prio [SLOT_COUNT];

	cell_cmd_t            cmd;
	logic [SLOT_COUNT-1:0] free_vec;
	logic [SLOT_COUNT-1:0] free_onehot;
	logic                 free_any;
	logic [SLOT_W-1:0]    free_slot;
	logic [SLOT_W-1:0]    tid_slot;
	logic                 tid_active;
	logic                 prio_bad;
	logic                 yield_move;
	logic                 dec_err;
	logic                 hole_any;

	assign s_axis_tready = (state_q == S_IDLE);
	assign m_axis_tvalid = m_tvalid_q;
	assign m_axis_tdata  = m_tdata_q;
	assign m_axis_tuser  = m_tuser_q;
	assign hole_any      = |cell_hole;

	always_comb begin
		free_vec    = ~(active_q | SLOT_COUNT'(1));
		free_onehot = free_vec & (~free_vec + SLOT_COUNT'(1));
		free_any    = |free_vec;
		free_slot   = '0;
		for (int i = 0; i < SLOT_COUNT; i++) begin
			if (free_onehot[i]) begin
				free_slot = free_slot | SLOT_W'(i);
			end
		end
	end

	always_comb begin
		tid_slot   = SLOT_W'(tid_q);
		tid_active = (int'(tid_q) < SLOT_COUNT) && active_q[tid_slot];
		prio_bad   = (prio_q >= IDLE_PRIORITY);
		yield_move = cell_valid[1] && !(cell_prio[0] < cell_prio[1]);
		unique case (kind_q)
			KIND_CREATE:   dec_err = prio_bad || !free_any;
			KIND_EXIT:     dec_err = (cell_slot[0] == '0);
			KIND_YIELD:    dec_err = 1'b0;
			KIND_SET_PRIO: dec_err = prio_bad || (tid_q == '0) || !tid_active;
			default:       dec_err = 1'b1;
		endcase
	end

	always_comb begin
		cmd.key_prio = key_prio_q;
		cmd.op       = CELL_HOLD;
		unique case (state_q)
			S_DECIDE: begin
				if (!dec_err && (kind_q == KIND_EXIT ||
						(kind_q == KIND_YIELD && yield_move))) begin
					cmd.op = CELL_SHIFT;
				end
			end
			S_MARK:   cmd.op = CELL_MARK;
			S_BUBBLE: cmd.op = hole_any ? CELL_BUBBLE : CELL_HOLD;
			S_INSERT: cmd.op = CELL_INSERT;
			default:  cmd.op = CELL_HOLD;
		endcase
	end

	for (genvar i = 0; i < SLOT_COUNT; i++) begin : g_cell
		logic              l_valid;
		logic [SLOT_W-1:0] l_slot;
		logic [PRIO_W-1:0] l_prio;
		logic              l_hole;
		logic              l_gt;
		logic              r_valid;
		logic [SLOT_W-1:0] r_slot;
		logic [PRIO_W-1:0] r_prio;

		if (i == 0) begin : g_head
			assign l_valid = 1'b0;
			assign l_slot  = '0;
			assign l_prio  = '0;
			assign l_hole  = 1'b0;
			assign l_gt    = 1'b0;
		end else begin : g_body
			assign l_valid = cell_valid[i-1];
			assign l_slot  = cell_slot[i-1];
			assign l_prio  = cell_prio[i-1];
			assign l_hole  = cell_hole[i-1];
			assign l_gt    = cell_gt[i-1];
		end

		if (i == SLOT_COUNT - 1) begin : g_tail
			assign r_valid = 1'b0;
			assign r_slot  = '0;
			assign r_prio  = '0;
		end else begin : g_inner
			assign r_valid = cell_valid[i+1];
			assign r_slot  = cell_slot[i+1];
			assign r_prio  = cell_prio[i+1];
		end

		sprq_cell #(
			.SLOT_W        (SLOT_W),
			.IDLE_PRIORITY (IDLE_PRIORITY),
			.IS_HEAD       (i == 0)
		) u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.cmd         (cmd),
			.key_slot    (key_slot_q),
			.left_valid  (l_valid),
			.left_slot   (l_slot),
			.left_prio   (l_prio),
			.left_hole   (l_hole),
			.left_gt     (l_gt),
			.right_valid (r_valid),
			.right_slot  (r_slot),
			.right_prio  (r_prio),
			.valid       (cell_valid[i]),
			.hole        (cell_hole[i]),
			.slot        (cell_slot[i]),
			.prio        (cell_prio[i]),
			.gt          (cell_gt[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			kind_q     <= KIND_CREATE;
			tid_q      <= '0;
			prio_q     <= '0;
			before_q   <= '0;
			key_slot_q <= '0;
			key_prio_q <= '0;
			created_q  <= '0;
			err_q      <= 1'b0;
			active_q   <= SLOT_COUNT'(1);
			m_tvalid_q <= 1'b0;
			m_tdata_q  <= '0;
			m_tuser_q  <= '0;
		end else begin
			if (state_q == S_DONE && (!m_tvalid_q || m_axis_tready)) begin
				m_tvalid_q <= 1'b1;
			end else if (m_axis_tready) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (s_axis_tvalid) begin
						kind_q   <= kind_t'(s_axis_tuser);
						tid_q    <= s_axis_tdata[3:0];
						prio_q   <= s_axis_tdata[11:4];
						before_q <= cell_slot[0];
						state_q  <= S_DECIDE;
					end
				end
				S_DECIDE: begin
					err_q     <= dec_err;
					created_q <= (kind_q == KIND_CREATE && !dec_err) ? free_slot : '0;
					unique case (kind_q)
						KIND_CREATE: begin
							key_slot_q <= free_slot;
							key_prio_q <= prio_q;
							if (dec_err) begin
								state_q <= S_DONE;
							end else begin
								active_q[free_slot] <= 1'b1;
								state_q             <= S_INSERT;
							end
						end
						KIND_EXIT: begin
							if (!dec_err) begin
								active_q[cell_slot[0]] <= 1'b0;
							end
							state_q <= S_DONE;
						end
						KIND_YIELD: begin
							key_slot_q <= cell_slot[0];
							key_prio_q <= cell_prio[0];
							state_q    <= yield_move ? S_INSERT : S_DONE;
						end
						KIND_SET_PRIO: begin
							key_slot_q <= tid_slot;
							key_prio_q <= prio_q;
							state_q    <= dec_err ? S_DONE : S_MARK;
						end
						default: state_q <= S_DONE;
					endcase
				end
				S_MARK: begin
					state_q <= S_BUBBLE;
				end
				S_BUBBLE: begin
					if (!hole_any) begin
						state_q <= S_INSERT;
					end
				end
				S_INSERT: begin
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (!m_tvalid_q || m_axis_tready) begin
						m_tdata_q  <= {4'(created_q), 4'(cell_slot[0])};
						m_tuser_q  <= {err_q, cell_slot[0] != before_q};
						state_q    <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_idle_queued: assert property (@(posedge clk) disable iff (!arst_n)
		cell_valid[0])
		else $error("queue head cell is empty");

	a_single_hole: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(cell_hole))
		else $error("more than one hole in the queue");

	a_count_match: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_IDLE |-> $countones(cell_valid) == $countones(active_q))
		else $error("queued entries differ from active slots");

	a_no_hole_idle: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_INSERT |-> !hole_any)
		else $error("insert started while a hole remains");
`endif

endmodule
